// ----- sv/dmdt_pkg.sv -----
// Package with shared widths, defaults and codes for the decoded message dedup table.
package dmdt_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int HASH_W        = 16;
   localparam int PLO_W         = 64;
   localparam int PHI_W         = 16;
   localparam int SLOT_W        = 6;
   localparam int ENTRY_W       = 1 + HASH_W + PLO_W + PHI_W;

   localparam logic ACTION_OFFER = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_NEW     = 2'd0,
      VERDICT_DUP     = 2'd1,
      VERDICT_FULL    = 2'd2,
      VERDICT_CLEARED = 2'd3
   } verdict_type;

endpackage

// ----- sv/dmdt_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
module dmdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/decoded_message_dedup_table.sv -----
// Top level of the decoded message dedup table: linear probing hash set over one RAM.
// An offer finds its start slot by reciprocal multiplication (S_MOD, S_REM), reads the RAM,
// probes one slot per cycle, then hands its result to the registered output once it is free.
// A clear writes every entry of the RAM to zero, one entry RAM write per cycle.
// One item is in work at a time; req_stall drops in the same cycle its result is shown.
// Reset is synchronous; afterwards a clearing pass over all SLOTS entries holds req_stall high.
module decoded_message_dedup_table #(
   parameter int SLOTS = dmdt_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [dmdt_pkg::HASH_W-1:0] req_msg_hash,
   input  logic [dmdt_pkg::PLO_W-1:0]  req_payload_low,
   input  logic [dmdt_pkg::PHI_W-1:0]  req_payload_high,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_verdict,
   output logic [dmdt_pkg::SLOT_W-1:0] rsp_slot
);

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int KEY_W   = dmdt_pkg::HASH_W + dmdt_pkg::PLO_W + dmdt_pkg::PHI_W;
   localparam int USED_B  = dmdt_pkg::ENTRY_W - 1;
   localparam int PROD_W  = dmdt_pkg::HASH_W + 32;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_MOD,
      S_REM,
      S_READ,
      S_CHECK,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [IDX_W-1:0]                    idx_ff, idx_in;
   logic [IDX_W-1:0]                    probes_ff, probes_in;
   logic [dmdt_pkg::HASH_W-1:0]         quot_ff, quot_in;
   logic [KEY_W-1:0]                    key_ff, key_in;
   dmdt_pkg::verdict_type               res_verdict_ff, res_verdict_in;
   logic [dmdt_pkg::SLOT_W-1:0]         res_slot_ff, res_slot_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   dmdt_pkg::verdict_type               rsp_verdict_ff, rsp_verdict_in;
   logic [dmdt_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;

   logic [IDX_W-1:0]                    idx_next;
   logic [dmdt_pkg::HASH_W-1:0]         hash_key;
   logic [PROD_W-1:0]                   quot_prod;
   logic [dmdt_pkg::HASH_W-1:0]         rem_full;
   logic [IDX_W-1:0]                    rem_idx;
   logic                                out_free;
   logic                                req_take;
   logic                                entry_match;

   logic                                ram_wr_en;
   logic [dmdt_pkg::ENTRY_W-1:0]        ram_wr_data;
   logic [IDX_W-1:0]                    ram_rd_addr;
   logic [dmdt_pkg::ENTRY_W-1:0]        ram_rd_data;

   dmdt_ram #(
      .WIDTH (dmdt_pkg::ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign idx_next    = (idx_ff == IDX_W'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;
   assign hash_key    = key_ff[KEY_W-1 -: dmdt_pkg::HASH_W];
   assign quot_prod   = PROD_W'(hash_key) * PROD_W'(RECIP);
   assign rem_full    = hash_key - dmdt_pkg::HASH_W'(quot_ff * dmdt_pkg::HASH_W'(SLOTS));
   assign rem_idx     = (rem_full >= dmdt_pkg::HASH_W'(SLOTS)) ?
                        IDX_W'(rem_full - dmdt_pkg::HASH_W'(SLOTS)) : IDX_W'(rem_full);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_take    = req_valid && !req_stall;
   assign entry_match = (ram_rd_data[KEY_W-1:0] == key_ff);
   assign ram_rd_addr = (state_ff == S_CHECK) ? idx_next : idx_ff;
   assign ram_wr_en   = (state_ff == S_INIT) || (state_ff == S_CLEAR) ||
                        ((state_ff == S_CHECK) && !ram_rd_data[USED_B]);
   assign ram_wr_data = (state_ff == S_CHECK) ? {1'b1, key_ff} : '0;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      probes_in      = probes_ff;
      quot_in        = quot_ff;
      key_in         = key_ff;
      res_verdict_in = res_verdict_ff;
      res_slot_in    = res_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_slot_in    = rsp_slot_ff;
      unique case (state_ff)
         S_INIT: begin
            idx_in = idx_next;
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               key_in     = {req_msg_hash, req_payload_low, req_payload_high};
               idx_in     = '0;
               probes_in  = '0;
               if (req_action == dmdt_pkg::ACTION_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            quot_in  = quot_prod[PROD_W-1 -: dmdt_pkg::HASH_W];
            state_in = S_REM;
         end
         S_REM: begin
            idx_in   = rem_idx;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!ram_rd_data[USED_B]) begin
               res_verdict_in = dmdt_pkg::VERDICT_NEW;
               res_slot_in    = dmdt_pkg::SLOT_W'(idx_ff);
               state_in       = S_DONE;
            end else if (entry_match) begin
               res_verdict_in = dmdt_pkg::VERDICT_DUP;
               res_slot_in    = dmdt_pkg::SLOT_W'(idx_ff);
               state_in       = S_DONE;
            end else if (probes_ff == IDX_W'(SLOTS - 1)) begin
               res_verdict_in = dmdt_pkg::VERDICT_FULL;
               res_slot_in    = '0;
               state_in       = S_DONE;
            end else begin
               idx_in    = idx_next;
               probes_in = probes_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            idx_in = idx_next;
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               res_verdict_in = dmdt_pkg::VERDICT_CLEARED;
               res_slot_in    = '0;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_slot_in    = res_slot_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      probes_ff      <= probes_in;
      quot_ff        <= quot_in;
      key_ff         <= key_in;
      res_verdict_ff <= res_verdict_in;
      res_slot_ff    <= res_slot_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_slot    = rsp_slot_ff;

`ifndef SYNTHESIS
   a_empty_slot_written: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && !ram_rd_data[USED_B]) |-> ram_wr_en)
      else $error("Empty slot found but no entry write issued.");

   a_init_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> req_stall)
      else $error("Input accepted during the clearing pass.");

   a_take_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_MOD || state_ff == S_CLEAR))
      else $error("Accepted transfer did not start modulo or clear.");

   a_result_loads_free_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("Result left the done state while the output was held.");
`endif

endmodule
